// ===== rtl/fixed_point_alu_core_assert.svh =====
// Assertion macros for the fixed-point ALU.
`ifndef FIXED_POINT_ALU_CORE_ASSERT_SVH
`define FIXED_POINT_ALU_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPA_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("fixed-point ALU assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("fixed-point ALU assertion failed");

`endif

// ===== rtl/fpa_pkg.sv =====
`default_nettype none
package fpa_pkg;

  localparam int unsigned FracBitsDefault = 8;
  localparam int unsigned WordW = 32;

  typedef enum logic [3:0] {
    ACT_ADD = 4'd0,
    ACT_SUB = 4'd1,
    ACT_MUL = 4'd2,
    ACT_DIV = 4'd3,
    ACT_MIN = 4'd4,
    ACT_MAX = 4'd5,
    ACT_INC = 4'd6,
    ACT_DEC = 4'd7,
    ACT_I2F = 4'd8,
    ACT_F2I = 4'd9
  } action_t;

  typedef struct packed {
    logic [3:0]        action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] result_word;
    logic              a_equal_b;
    logic              a_greater_b;
    logic              a_less_b;
    logic              divide_by_zero;
  } out_rsp_t;

  // Fields that travel beside the divider, unchanged but for res, which takes the product for ACT_MUL.
  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] res;
    logic        eq;
    logic        gt;
    logic        lt;
    logic        dz;
    logic        neg;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/fpa_div_step.sv =====
`default_nettype none
module fpa_div_step #(
  parameter int unsigned NumW = 40
) (
  input  wire logic [31:0]     rem_cur,
  input  wire logic [NumW-1:0] num_cur,
  input  wire logic [31:0]     dvs,
  output logic [31:0]          rem_nxt,
  output logic [NumW-1:0]      num_nxt
);

  logic [32:0] r2;
  logic [33:0] diff;
  logic        qbit;

  always_comb begin
    r2   = {rem_cur, num_cur[NumW-1]};
    diff = {1'b0, r2} - {2'b00, dvs};
    qbit = ~diff[33];
    if (qbit) begin
      rem_nxt = diff[31:0];
    end else begin
      rem_nxt = r2[31:0];
    end
    num_nxt = {num_cur[NumW-2:0], qbit};
  end

endmodule
`default_nettype wire

// ===== rtl/fixed_point_alu_core.sv =====
// Channel | Ports                          | Payload
// input   | in_valid, in_stall, in_data    | fpa_pkg::in_req_t
// output  | out_valid, out_stall, out_data | fpa_pkg::out_rsp_t
// One request enters per cycle unless a valid output is stalled; each request passes
// s0, stage 0, the restoring divider with one quotient bit per stage, and the output register.
// A stall of a valid output freezes the whole pipeline; in_stall is out_stall gated by out_valid.
// Reset clears only the valid bits of the stages.
`default_nettype none
module fixed_point_alu_core #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire fpa_pkg::in_req_t in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output fpa_pkg::out_rsp_t    out_data
);
  import fpa_pkg::*;

  localparam int unsigned NumW = WordW + FRAC_BITS;

  logic           en;
  logic           s0_vld_r;
  in_req_t        s0_r;

  logic           vld_r  [0:NumW];
  side_t          side_r [0:NumW];
  logic [31:0]    rem_r  [0:NumW];
  logic [NumW-1:0] num_r [0:NumW];
  logic [31:0]    dvs_r  [0:NumW];
  logic signed [63:0] prod_r;

  side_t          side_nxt;
  logic [31:0]    abs_a;
  logic [31:0]    abs_b;
  logic signed [63:0] mul_sh;

  logic           out_vld_r;
  out_rsp_t       out_r;
  out_rsp_t       out_nxt;
  logic [NumW-1:0] q_signed;

  assign en       = ~(out_vld_r & out_stall);
  assign in_stall = out_vld_r & out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= in_data;
    end
  end

  always_comb begin
    abs_a = s0_r.operand_a[31] ? 32'(-s0_r.operand_a) : 32'(s0_r.operand_a);
    abs_b = s0_r.operand_b[31] ? 32'(-s0_r.operand_b) : 32'(s0_r.operand_b);
    side_nxt.action = s0_r.action;
    side_nxt.eq     = s0_r.operand_a == s0_r.operand_b;
    side_nxt.gt     = s0_r.operand_a > s0_r.operand_b;
    side_nxt.lt     = s0_r.operand_a < s0_r.operand_b;
    side_nxt.dz     = (s0_r.action == ACT_DIV) && (s0_r.operand_b == 32'sd0);
    side_nxt.neg    = s0_r.operand_a[31] ^ s0_r.operand_b[31];
    case (action_t'(s0_r.action))
      ACT_ADD: side_nxt.res = 32'(s0_r.operand_a + s0_r.operand_b);
      ACT_SUB: side_nxt.res = 32'(s0_r.operand_a - s0_r.operand_b);
      ACT_MIN: side_nxt.res = side_nxt.lt ? s0_r.operand_a : s0_r.operand_b;
      ACT_MAX: side_nxt.res = side_nxt.gt ? s0_r.operand_a : s0_r.operand_b;
      ACT_INC: side_nxt.res = 32'(s0_r.operand_a + 32'sd1);
      ACT_DEC: side_nxt.res = 32'(s0_r.operand_a - 32'sd1);
      ACT_I2F: side_nxt.res = 32'(s0_r.operand_a <<< FRAC_BITS);
      ACT_F2I: side_nxt.res = 32'(s0_r.operand_a >>> FRAC_BITS);
      default: side_nxt.res = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      prod_r    <= 64'(s0_r.operand_a) * 64'(s0_r.operand_b);
      rem_r[0]  <= 32'd0;
      num_r[0]  <= NumW'(abs_a) << FRAC_BITS;
      dvs_r[0]  <= abs_b;
    end
  end

  assign mul_sh = prod_r >>> FRAC_BITS;

  for (genvar k = 0; k < NumW; k++) begin : g_div
    logic [31:0]     rem_nxt;
    logic [NumW-1:0] num_nxt;
    side_t           side_k;

    fpa_div_step #(.NumW(NumW)) u_step (
      .rem_cur (rem_r[k]),
      .num_cur (num_r[k]),
      .dvs     (dvs_r[k]),
      .rem_nxt (rem_nxt),
      .num_nxt (num_nxt)
    );

    always_comb begin
      side_k = side_r[k];
      if (k == 0 && side_r[k].action == ACT_MUL) begin
        side_k.res = mul_sh[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= side_k;
        rem_r[k+1]  <= rem_nxt;
        num_r[k+1]  <= num_nxt;
        dvs_r[k+1]  <= dvs_r[k];
      end
    end
  end

  always_comb begin
    q_signed               = side_r[NumW].neg ? -num_r[NumW] : num_r[NumW];
    out_nxt.a_equal_b      = side_r[NumW].eq;
    out_nxt.a_greater_b    = side_r[NumW].gt;
    out_nxt.a_less_b       = side_r[NumW].lt;
    out_nxt.divide_by_zero = side_r[NumW].dz;
    if (side_r[NumW].action == ACT_DIV) begin
      out_nxt.result_word = side_r[NumW].dz ? 32'sd0 : q_signed[31:0];
    end else begin
      out_nxt.result_word = side_r[NumW].res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[NumW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`include "fixed_point_alu_core_assert.svh"

  `FPA_ASSERT_NEXT(a_frozen, out_valid && out_stall, vld_r[NumW] == $past(vld_r[NumW]))
  `FPA_ASSERT_NOW(a_dz_zero, out_valid && out_data.divide_by_zero, out_data.result_word == 32'sd0)
  `FPA_ASSERT_NOW(a_cmp_onehot, out_valid,
    $onehot({out_data.a_equal_b, out_data.a_greater_b, out_data.a_less_b}))

endmodule
`default_nettype wire
